FILE: rtl/core/uem_pkg.sv
// ----------------------------------------------------------------------------
// uem_pkg
// Shared types and constants of the utilization moving average monitor.
// ----------------------------------------------------------------------------
package uem_pkg;

    localparam int AVG_W        = 10;
    localparam int PCT_W        = 7;
    localparam int QUOT_W       = 10;
    localparam int DIV_CNT_W    = 4;
    localparam int SUM_W        = 14;
    localparam int JOB_W        = 32;
    localparam int MIN_INT_W    = 20;
    localparam int JOB_LOAD_W   = 10;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_INDEX_W  = 1;
    localparam int STATUS_W     = 2;

    localparam logic [AVG_W-1:0]      LOAD_FULL        = 10'd1000;
    localparam logic [MIN_INT_W-1:0]  MIN_INTERVAL_RST = 20'd10000;
    localparam logic [JOB_LOAD_W-1:0] JOB_LOAD_RST     = 10'd50;

    // divide by ten: multiply by reciprocal, exact for the sums in use
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;
    localparam logic [12:0] PCT_RECIP     = 13'd6554;
    localparam int          PCT_SHIFT     = 16;
    localparam logic [3:0]  PCT_ROUND     = 4'd5;

    localparam logic [DIV_CNT_W-1:0] DIV_FIRST = 4'd9;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 4'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_JOB_LOAD     = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_PRIMED  = 2'd0,
        STATUS_SKIPPED = 2'd1,
        STATUS_UPDATED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_EMA,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    diff;
        logic    prime;
        logic    mul;
        logic    div_step;
        logic    ema;
        logic    commit;
        logic    emit;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic primed;
        logic too_soon;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/uem_controller.sv
// ----------------------------------------------------------------------------
// uem_controller
// Sequencer: difference and check for each sample, then for an updating one
// multiply, ten quotient steps and average update, then result transfer.
// ----------------------------------------------------------------------------
module uem_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  uem_pkg::dp_status_t stat,
    output uem_pkg::dp_cmd_t    cmd
);
    import uem_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            status_reg <= STATUS_PRIMED;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (!stat.primed)
                begin
                    status_next = STATUS_PRIMED;
                    state_next  = ST_DONE;
                end
                else if (stat.too_soon)
                begin
                    status_next = STATUS_SKIPPED;
                    state_next  = ST_DONE;
                end
                else
                begin
                    status_next = STATUS_UPDATED;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_EMA;
                end
            end
            ST_EMA:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        cmd.load      = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.diff      = (state_reg == ST_DIFF);
        cmd.prime     = (state_reg == ST_CHECK) && !stat.primed;
        cmd.mul       = (state_reg == ST_MUL);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.ema       = (state_reg == ST_EMA);
        cmd.commit    = (state_reg == ST_COMMIT);
        cmd.emit      = (state_reg == ST_DONE) && stat.out_free;
        cmd.status    = status_reg;
    end

endmodule

FILE: rtl/core/uem_datapath.sv
// ----------------------------------------------------------------------------
// uem_datapath
// Snapshots, deltas, busy ratio long division, per-core loads, moving
// averages, configuration registers and the result output register.
// ----------------------------------------------------------------------------
module uem_datapath
#(
    parameter int NUM_CORES = 3,
    parameter int TIME_BITS = 48,
    parameter int IN_W      = 200,
    parameter int OUT_W     = 48
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [uem_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [uem_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [IN_W-1:0]                    s_axis_tdata,
    input  uem_pkg::dp_cmd_t                   cmd,
    output uem_pkg::dp_status_t                stat,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [OUT_W-1:0]                   m_axis_tdata,
    output logic [uem_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import uem_pkg::*;

    localparam int NUM_W     = TIME_BITS + QUOT_W;
    localparam int TOTAL_LSB = TIME_BITS;
    localparam int JOBS_LSB  = 2 * TIME_BITS;
    localparam int BUSY_LSB  = JOBS_LSB + JOB_W * NUM_CORES;
    localparam int PCT_LSB   = AVG_W;
    localparam int CORE_LSB  = AVG_W + PCT_W;

    // configuration
    logic [MIN_INT_W-1:0]  min_interval_reg;
    logic [JOB_LOAD_W-1:0] job_load_reg;

    // sample capture
    logic [TIME_BITS-1:0] idle_in_reg;
    logic [TIME_BITS-1:0] total_in_reg;
    logic [JOB_W-1:0]     jobs_in_reg [NUM_CORES];
    logic [NUM_CORES-1:0] busy_in_reg;

    // persistent state
    logic                 primed_reg;
    logic [TIME_BITS-1:0] idle_snap_reg;
    logic [TIME_BITS-1:0] total_snap_reg;
    logic [JOB_W-1:0]     job_snap_reg [NUM_CORES];
    logic [AVG_W-1:0]     cpu_avg_reg;
    logic [AVG_W-1:0]     core_avg_reg [NUM_CORES];

    // working registers
    logic [TIME_BITS-1:0] d_idle_reg;
    logic [TIME_BITS-1:0] d_total_reg;
    logic [JOB_W-1:0]     delta_reg [NUM_CORES];
    logic [NUM_W-1:0]     rem_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [AVG_W-1:0]     load_reg [NUM_CORES];
    logic [SUM_W-1:0]     cpu_sum_reg;
    logic [SUM_W-1:0]     core_sum_reg [NUM_CORES];

    // output register
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic [STATUS_W-1:0]  out_user_reg;
    logic [OUT_W-1:0]     out_data_next;

    logic [TIME_BITS-1:0] busy_time;
    logic [NUM_W-1:0]     busy_ext;
    logic [NUM_W-1:0]     busy_scaled;
    logic [NUM_W-1:0]     div_shifted;
    logic [NUM_W:0]       div_trial;
    logic [AVG_W-1:0]     cpu_inst;
    logic [AVG_W-1:0]     core_load [NUM_CORES];
    logic [AVG_W-1:0]     cpu_avg_new;
    logic [AVG_W-1:0]     core_avg_new [NUM_CORES];
    logic [AVG_W:0]       pct_base;
    logic [23:0]          pct_prod;

    function automatic logic [SUM_W-1:0] ema_sum(input logic [AVG_W-1:0] avg,
                                                 input logic [AVG_W-1:0] inst);
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] x;
        a = SUM_W'(avg);
        x = SUM_W'(inst);
        // seeded average: inst * 10, so the divide returns inst
        if (avg == '0)
        begin
            return (x << 3) + (x << 1);
        end
        return (a << 1) + (x << 3);
    endfunction

    function automatic logic [AVG_W-1:0] div10(input logic [SUM_W-1:0] s);
        logic [SUM_W+15:0] p;
        p = SUM_W'(s) * RECIP10;
        return p[RECIP10_SHIFT +: AVG_W];
    endfunction

    // busy time and scaling by 1000 as shifts
    always_comb
    begin
        busy_time   = (d_total_reg > d_idle_reg) ? (d_total_reg - d_idle_reg) : '0;
        busy_ext    = NUM_W'(busy_time);
        busy_scaled = (busy_ext << 10) - (busy_ext << 5) + (busy_ext << 3);
        div_shifted = NUM_W'(d_total_reg) << div_cnt_reg;
        div_trial   = {1'b0, rem_reg} - {1'b0, div_shifted};
        if (d_total_reg == '0)
        begin
            cpu_inst = '0;
        end
        else if (quot_reg > LOAD_FULL)
        begin
            cpu_inst = LOAD_FULL;
        end
        else
        begin
            cpu_inst = quot_reg;
        end
    end

    for (genvar i = 0; i < NUM_CORES; i++)
    begin : g_lane
        logic [2*JOB_LOAD_W-1:0] prod;
        always_comb
        begin
            prod = delta_reg[i][JOB_LOAD_W-1:0] * job_load_reg;
            priority if (busy_in_reg[i])
            begin
                core_load[i] = LOAD_FULL;
            end
            else if (delta_reg[i] >= JOB_W'(LOAD_FULL))
            begin
                core_load[i] = (job_load_reg != '0) ? LOAD_FULL : '0;
            end
            else if (prod > (2*JOB_LOAD_W)'(LOAD_FULL))
            begin
                core_load[i] = LOAD_FULL;
            end
            else
            begin
                core_load[i] = prod[AVG_W-1:0];
            end
            core_avg_new[i] = div10(core_sum_reg[i]);
        end
    end

    always_comb
    begin
        cpu_avg_new = div10(cpu_sum_reg);
        pct_base    = {1'b0, cpu_avg_reg} + (AVG_W+1)'(PCT_ROUND);
        pct_prod    = pct_base * PCT_RECIP;
        out_data_next = '0;
        out_data_next[0 +: AVG_W]       = cpu_avg_reg;
        out_data_next[PCT_LSB +: PCT_W] = pct_prod[PCT_SHIFT +: PCT_W];
        for (int i = 0; i < NUM_CORES; i++)
        begin
            out_data_next[CORE_LSB + AVG_W*i +: AVG_W] = core_avg_reg[i];
        end
    end

    // configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= MIN_INTERVAL_RST;
            job_load_reg     <= JOB_LOAD_RST;
            primed_reg       <= 1'b0;
            idle_snap_reg    <= '0;
            total_snap_reg   <= '0;
            cpu_avg_reg      <= '0;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                job_snap_reg[i] <= '0;
                core_avg_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                    CFG_JOB_LOAD:     job_load_reg     <= cfg_data[JOB_LOAD_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.prime || cmd.commit)
            begin
                primed_reg     <= 1'b1;
                idle_snap_reg  <= idle_in_reg;
                total_snap_reg <= total_in_reg;
                for (int i = 0; i < NUM_CORES; i++)
                begin
                    job_snap_reg[i] <= jobs_in_reg[i];
                end
            end
            if (cmd.commit)
            begin
                cpu_avg_reg <= cpu_avg_new;
                for (int i = 0; i < NUM_CORES; i++)
                begin
                    core_avg_reg[i] <= core_avg_new[i];
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idle_in_reg  <= s_axis_tdata[0 +: TIME_BITS];
            total_in_reg <= s_axis_tdata[TOTAL_LSB +: TIME_BITS];
            busy_in_reg  <= s_axis_tdata[BUSY_LSB +: NUM_CORES];
            for (int i = 0; i < NUM_CORES; i++)
            begin
                jobs_in_reg[i] <= s_axis_tdata[JOBS_LSB + JOB_W*i +: JOB_W];
            end
        end
        if (cmd.diff)
        begin
            d_idle_reg  <= idle_in_reg - idle_snap_reg;
            d_total_reg <= total_in_reg - total_snap_reg;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                delta_reg[i] <= jobs_in_reg[i] - job_snap_reg[i];
            end
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < NUM_CORES; i++)
            begin
                load_reg[i] <= core_load[i];
            end
        end
        if (cmd.ema)
        begin
            cpu_sum_reg <= ema_sum(cpu_avg_reg, cpu_inst);
            for (int i = 0; i < NUM_CORES; i++)
            begin
                core_sum_reg[i] <= ema_sum(core_avg_reg[i], load_reg[i]);
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= cmd.status;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= DIV_FIRST;
            quot_reg    <= '0;
            rem_reg     <= '0;
        end
        else if (cmd.mul)
        begin
            div_cnt_reg <= DIV_FIRST;
            quot_reg    <= '0;
            rem_reg     <= busy_scaled;
        end
        else if (cmd.div_step)
        begin
            if (!div_trial[NUM_W])
            begin
                rem_reg <= div_trial[NUM_W-1:0];
            end
            quot_reg    <= {quot_reg[QUOT_W-2:0], ~div_trial[NUM_W]};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.primed   = primed_reg;
    assign stat.too_soon = d_total_reg < TIME_BITS'(min_interval_reg);
    assign stat.div_last = (div_cnt_reg == DIV_LAST);
    assign stat.out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

FILE: rtl/core/utilization_ema_monitor_unit.sv
// ----------------------------------------------------------------------------
// utilization_ema_monitor_unit
// CPU and accelerator core utilization moving averages in tenths of a percent.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A sample that updates the averages passes
// through difference, check, multiply, a restoring divider for the busy
// ratio that resolves one of ten quotient bits per cycle, two average steps
// and the result transfer. A priming or skipped sample goes from the check
// straight to the result transfer. The result sits in an output register,
// so the next sample is taken while it waits.
module utilization_ema_monitor_unit
#(
    parameter int NUM_CORES = 3,
    parameter int TIME_BITS = 48,
    parameter int IN_W  = ((2*TIME_BITS + 33*NUM_CORES + 7) / 8) * 8,
    parameter int OUT_W = ((17 + 10*NUM_CORES + 7) / 8) * 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // idle_us, total_us, jobs_core0.., busy_core0..
    input  logic [IN_W-1:0]                 s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cpu_tenths, cpu_percent, apu0_tenths..
    output logic [OUT_W-1:0]                m_axis_tdata,
    // status
    output logic [uem_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import uem_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    uem_controller u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    uem_datapath
    #(
        .NUM_CORES (NUM_CORES),
        .TIME_BITS (TIME_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // one sample in flight at a time
    a_single_sample: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while another is in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STATUS_PRIMED ||
                           m_axis_tuser == STATUS_SKIPPED ||
                           m_axis_tuser == STATUS_UPDATED))
        else $error("invalid status code on result");

    a_cpu_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[AVG_W-1:0] <= LOAD_FULL)
        else $error("cpu average above full load");

endmodule

FILE: tb/tb_utilization_ema_monitor_unit.sv
// ----------------------------------------------------------------------------
// tb_utilization_ema_monitor_unit
// Self-checking bench for the utilization moving average monitor. A short
// table of directed samples (priming, skip, interval edge, counter wrap,
// saturation, zero elapsed time) is followed by random well-formed sample
// sequences with some noise. Each result is checked field by field against
// a typed row's table values or an in-bench model of the averages. The bench
// runs through several register settings and several idle and stall
// patterns, including one long output hold-off that backs up the input side.
// ----------------------------------------------------------------------------
module tb_utilization_ema_monitor_unit;

    import uem_pkg::*;

    localparam int NUM_CORES     = 3;
    localparam int TIME_BITS     = 48;
    localparam int IN_W          = ((2*TIME_BITS + 33*NUM_CORES + 7) / 8) * 8;
    localparam int OUT_W         = ((17 + 10*NUM_CORES + 7) / 8) * 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRESSURE_HOLD = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [2:0]        busy;
        logic [2:0][31:0]  jobs;
        logic [47:0]       total_us;
        logic [47:0]       idle_us;
    } usage_sample_t;

    typedef struct packed {
        status_t           status;
        logic [9:0]        cpu_tenths;
        logic [6:0]        cpu_percent;
        logic [2:0][9:0]   core_tenths;
    } avg_report_t;

    typedef struct {
        usage_sample_t sample;
        bit            typed;
        avg_report_t   report;
    } table_row_t;

    typedef struct {
        bit          write_cfg;
        logic [19:0] min_data;
        logic [19:0] load_data;
        int          src_idle;
        int          sink_stall;
        bit          pressure;
        int          first_row;
        int          row_count;
        int          random_items;
    } phase_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MIN_INTERVAL;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // idle_us, total_us, jobs_core0, jobs_core1, jobs_core2, busy_core0..2
    logic [IN_W-1:0]        s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // cpu_tenths, cpu_percent, apu0_tenths, apu1_tenths, apu2_tenths
    logic [OUT_W-1:0]       m_axis_tdata;
    // status
    logic [STATUS_W-1:0]    m_axis_tuser;

    // model state and register copies
    logic                   pr_primed = 1'b0;
    logic [47:0]            pr_idle_snap = '0;
    logic [47:0]            pr_total_snap = '0;
    logic [2:0][31:0]       pr_job_snap = '0;
    int unsigned            pr_cpu_avg = 0;
    int unsigned            pr_core_avg [3] = '{0, 0, 0};
    logic [MIN_INT_W-1:0]   cfg_min_interval = MIN_INTERVAL_RST;
    logic [JOB_LOAD_W-1:0]  cfg_job_load = JOB_LOAD_RST;

    avg_report_t            averages_due [$];
    table_row_t             directed_rows [$];
    usage_sample_t          last_sent = '0;
    int                     error_count = 0;
    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    bit                     pressure_go = 1'b0;
    bit                     pressure_done = 1'b0;

    utilization_ema_monitor_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned ema_step(int unsigned avg, int unsigned inst);
        if (avg == 0)
            return inst;
        return (avg * 2 + inst * 8) / 10;
    endfunction

    function automatic avg_report_t predict_averages(usage_sample_t s);
        avg_report_t r;
        logic [47:0] d_idle;
        logic [47:0] d_total;
        logic [63:0] busy_us;
        logic [31:0] delta;
        int unsigned inst;
        int unsigned load;
        r = '0;
        if (!pr_primed)
        begin
            pr_primed     = 1'b1;
            pr_idle_snap  = s.idle_us;
            pr_total_snap = s.total_us;
            pr_job_snap   = s.jobs;
            r.status      = STATUS_PRIMED;
        end
        else
        begin
            d_idle  = s.idle_us - pr_idle_snap;
            d_total = s.total_us - pr_total_snap;
            if (d_total < 48'(cfg_min_interval))
            begin
                r.status = STATUS_SKIPPED;
            end
            else
            begin
                busy_us = (d_total > d_idle) ? 64'(d_total - d_idle) : 64'd0;
                inst = 0;
                // zero elapsed time: no division, load stays zero
                if (d_total != 0)
                    inst = 32'((busy_us * 64'd1000) / 64'(d_total));
                if (inst > LOAD_FULL)
                    inst = LOAD_FULL;
                for (int c = 0; c < NUM_CORES; c++)
                begin
                    delta = s.jobs[c] - pr_job_snap[c];
                    if (s.busy[c])
                        load = LOAD_FULL;
                    else if (delta >= LOAD_FULL)
                        load = (cfg_job_load != 0) ? LOAD_FULL : 0;
                    else
                    begin
                        load = delta * cfg_job_load;
                        if (load > LOAD_FULL)
                            load = LOAD_FULL;
                    end
                    pr_core_avg[c] = ema_step(pr_core_avg[c], load);
                end
                pr_job_snap   = s.jobs;
                pr_cpu_avg    = ema_step(pr_cpu_avg, inst);
                pr_idle_snap  = s.idle_us;
                pr_total_snap = s.total_us;
                r.status      = STATUS_UPDATED;
            end
        end
        r.cpu_tenths  = 10'(pr_cpu_avg);
        r.cpu_percent = 7'((pr_cpu_avg + 5) / 10);
        for (int c = 0; c < NUM_CORES; c++)
            r.core_tenths[c] = 10'(pr_core_avg[c]);
        return r;
    endfunction

    function automatic void add_row(logic [47:0] idle, logic [47:0] total,
                                    logic [31:0] j0, logic [31:0] j1, logic [31:0] j2,
                                    logic [2:0] busy, bit typed = 1'b0,
                                    status_t st = STATUS_PRIMED, int cpu = 0, int pct = 0,
                                    int a0 = 0, int a1 = 0, int a2 = 0);
        table_row_t row;
        row.sample.idle_us     = idle;
        row.sample.total_us    = total;
        row.sample.jobs        = {j2, j1, j0};
        row.sample.busy        = busy;
        row.typed              = typed;
        row.report.status      = st;
        row.report.cpu_tenths  = 10'(cpu);
        row.report.cpu_percent = 7'(pct);
        row.report.core_tenths = {10'(a2), 10'(a1), 10'(a0)};
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    endtask

    // caller stands at a falling edge; returns at a falling edge
    task automatic push_sample(usage_sample_t s, bit typed, avg_report_t typed_report);
        avg_report_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({s.busy, s.jobs, s.total_us, s.idle_us});
        do @(posedge clk); while (!s_axis_tready);
        predicted = predict_averages(s);
        averages_due.push_back(typed ? typed_report : predicted);
        last_sent = s;
        @(negedge clk);
    endtask

    initial
    begin : sink_drive
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (pressure_go && !pressure_done)
            begin
                hold = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin : result_check
        avg_report_t want;
        avg_report_t got;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (averages_due.size() == 0)
                    report_mismatch("result with no sample pending", 64'(m_axis_tdata), 0);
                else
                begin
                    want = averages_due.pop_front();
                    got.status      = status_t'(m_axis_tuser);
                    got.cpu_tenths  = m_axis_tdata[9:0];
                    got.cpu_percent = m_axis_tdata[16:10];
                    got.core_tenths = m_axis_tdata[46:17];
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.cpu_tenths !== want.cpu_tenths)
                        report_mismatch("cpu_tenths", 64'(got.cpu_tenths),
                                        64'(want.cpu_tenths));
                    if (got.cpu_percent !== want.cpu_percent)
                        report_mismatch("cpu_percent", 64'(got.cpu_percent),
                                        64'(want.cpu_percent));
                    for (int c = 0; c < NUM_CORES; c++)
                        if (got.core_tenths[c] !== want.core_tenths[c])
                            report_mismatch($sformatf("apu%0d_tenths", c),
                                            64'(got.core_tenths[c]),
                                            64'(want.core_tenths[c]));
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        phase_t        phases [6];
        usage_sample_t s;
        logic [47:0]   dt;
        logic [47:0]   di;
        int unsigned   pick;

        // priming, skip, interval edge, extremes, wrap, over-idle, big job deltas
        add_row(48'd0, 48'd0, 0, 0, 0, 3'b000, 1'b1, STATUS_PRIMED, 0, 0, 0, 0, 0);
        add_row(48'd0, 48'd5000, 0, 0, 0, 3'b000, 1'b1, STATUS_SKIPPED, 0, 0, 0, 0, 0);
        add_row(48'd0, 48'd10000, 0, 0, 0, 3'b000, 1'b1, STATUS_UPDATED,
                1000, 100, 0, 0, 0);
        add_row(48'd10000, 48'd20000, 0, 0, 0, 3'b111, 1'b1, STATUS_UPDATED,
                200, 20, 1000, 1000, 1000);
        add_row(48'd10000, 48'd29999, 0, 0, 0, 3'b000, 1'b1, STATUS_SKIPPED,
                200, 20, 1000, 1000, 1000);
        add_row(48'd10000, 48'd30000, 5, 20, 1000, 3'b000);
        add_row(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 3'b101);
        add_row(48'd100, 48'd50000, 10, 3, 0, 3'b010);
        add_row(48'd200000, 48'd70000, 10, 3, 0, 3'b000);
        add_row(48'd205000, 48'd90000, 2010, 3, 0, 3'b000);
        add_row(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                32'h5555_5555, 3'b010);
        add_row(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 3'b101);
        // zero elapsed time, then large job deltas with zero per-job load
        add_row(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 3'b000);
        add_row(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAB, 32'hAAAA_BE32, 32'h5555_555F,
                32'hAAAA_AAAA, 3'b000);

        phases[0] = '{1'b0, 20'd0, 20'd0, 0, 0, 1'b0, 0, 12, 0};
        phases[1] = '{1'b1, 20'd0, 20'd0, 0, 0, 1'b0, 12, 2, 560};
        phases[2] = '{1'b1, 20'hFFFFF, 20'hFFFFF, 80, 0, 1'b0, 0, 0, 360};
        phases[3] = '{1'b1, 20'd1000000, 20'd1000, 0, 80, 1'b0, 0, 0, 360};
        phases[4] = '{1'b1, 20'($urandom_range(50000)), 20'($urandom), 20, 20, 1'b0,
                      0, 0, 360};
        phases[5] = '{1'b1, 20'd10000, 20'd50, 0, 0, 1'b1, 0, 0, 360};

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (phases[p])
        begin
            while (averages_due.size() != 0)
                @(negedge clk);
            if (phases[p].write_cfg)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    cfg_valid <= 1'b1;
                    cfg_index <= (k == 0) ? CFG_MIN_INTERVAL : CFG_JOB_LOAD;
                    cfg_data  <= (k == 0) ? phases[p].min_data : phases[p].load_data;
                    do @(posedge clk); while (!cfg_ready);
                    if (k == 0)
                        cfg_min_interval = phases[p].min_data[MIN_INT_W-1:0];
                    else
                        cfg_job_load = phases[p].load_data[JOB_LOAD_W-1:0];
                    @(negedge clk);
                end
                cfg_valid <= 1'b0;
            end
            src_idle_pct   = phases[p].src_idle;
            sink_stall_pct = phases[p].sink_stall;
            if (phases[p].pressure)
                pressure_go = 1'b1;

            for (int i = phases[p].first_row;
                 i < phases[p].first_row + phases[p].row_count; i++)
                push_sample(directed_rows[i].sample, directed_rows[i].typed,
                            directed_rows[i].report);

            for (int n = 0; n < phases[p].random_items; n++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    // noise: unrelated counter values
                    s.idle_us  = 48'({$urandom, $urandom});
                    s.total_us = 48'({$urandom, $urandom});
                    s.jobs     = {$urandom, $urandom, $urandom};
                    s.busy     = 3'($urandom_range(7));
                end
                else
                begin
                    pick = $urandom_range(9);
                    case (pick)
                        0: dt = 48'd0;
                        1: dt = (cfg_min_interval == 0) ? 48'd0 :
                                48'($urandom_range(int'(cfg_min_interval) - 1, 0));
                        2: dt = 48'(cfg_min_interval);
                        3: dt = (cfg_min_interval == 0) ? 48'd0 :
                                48'(cfg_min_interval) - 48'd1;
                        9: dt = 48'({$urandom, $urandom});
                        default: dt = 48'(cfg_min_interval) + 48'($urandom_range(200000));
                    endcase
                    pick = $urandom_range(9);
                    if (pick < 7)
                        di = (dt == 0) ? 48'd0 :
                             48'({$urandom, $urandom} % (64'(dt) + 64'd1));
                    else if (pick == 7)
                        di = dt;
                    else if (pick == 8)
                        di = dt + 48'($urandom_range(5000));
                    else
                        di = 48'd0;
                    s.total_us = last_sent.total_us + dt;
                    s.idle_us  = last_sent.idle_us + di;
                    for (int c = 0; c < NUM_CORES; c++)
                    begin
                        pick = $urandom_range(19);
                        if (pick < 15)
                            s.jobs[c] = last_sent.jobs[c] + $urandom_range(30);
                        else if (pick < 19)
                            s.jobs[c] = last_sent.jobs[c] + $urandom_range(1500);
                        else
                            s.jobs[c] = $urandom;
                        s.busy[c] = ($urandom_range(3) == 0);
                    end
                end
                push_sample(s, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
        end

        while (averages_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
